// File: design/bpc_pkg.sv
// Shared types and constants of the barometric pressure compensation unit.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 48;

   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_COEFFS    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PRESS_COEFFS_A = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PRESS_COEFFS_B = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_PRESS_COEFFS_C = 2'd3;

   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 96;

   localparam int unsigned FRONT_STAGES = 12;
   localparam int unsigned DIV_STAGES   = 64;
   localparam int unsigned BACK_STAGES  = 6;
   localparam int unsigned LATENCY      = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

   localparam logic signed [32:0] TEMP_OFFSET  = 33'sd128000;
   localparam logic signed [63:0] VAR1_OFFSET  = 64'sh0000_8000_0000_0000;
   localparam logic [63:0]        PRESS_FULL   = 64'd1048576;
   localparam logic signed [63:0] PRESS_SCALE  = 64'sd3125;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic signed [31:0] fine_temperature;
      logic               divisor_zero;
   } side_type;

endpackage
`default_nettype wire

// File: design/barometric_pressure_compensation_unit.sv
// Top level: pipelined integer barometric pressure and temperature compensation.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Input channel req_*: one transaction carries a raw 20-bit temperature and a
//   raw 20-bit pressure conversion. Result channel rsp_*: one transaction per
//   input with compensated temperature (0.01 degC), fine temperature and
//   pressure in unsigned Q24.8 Pa; rsp_tuser flags a zero pressure divisor, in
//   which case the pressure field is 0.
//   Calibration: four 48-bit registers written through csr_we/csr_addr/csr_wdata;
//   the user writes them only while no transaction is in flight (not enforced).
// Throughput and pipeline
//   One transaction enters per cycle unless the output stalls; each result
//   passes through 12 front stages, 64 divider stages and 6 back stages. The
//   latency is set by the restoring divider, one quotient bit per stage.
// Reset
//   Synchronous active-high reset empties the pipeline and clears the
//   calibration registers to zero.
// Backpressure
//   When a result waits with rsp_tready low, the whole pipeline holds and
//   req_tready drops; nothing is lost or repeated.
module barometric_pressure_compensation_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [19:0] raw_temperature, [39:20] raw_pressure
   input  wire logic [bpc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [31:0] temperature_centi, [63:32] fine_temperature, [95:64] pressure_q24_8
   output logic [bpc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] divisor_zero
   output logic                                rsp_tuser,
   input  wire logic                           csr_we,
   input  wire logic [bpc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [bpc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bpc_pkg::*;

   // signed divide by 2^k, truncating toward zero
   function automatic logic signed [31:0] sdiv32(input logic signed [31:0] x,
                                                 input int unsigned k);
      logic [31:0] bias;
      bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
      return (x + $signed(bias)) >>> k;
   endfunction

   function automatic logic signed [63:0] sdiv64(input logic signed [63:0] x,
                                                 input int unsigned k);
      logic [63:0] bias;
      bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
      return (x + $signed(bias)) >>> k;
   endfunction

   // ---------------- calibration registers ----------------
   logic [CSR_DATA_W-1:0] temp_coeffs_ff, press_a_ff, press_b_ff, press_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         press_c_ff     <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_TEMP_COEFFS:    temp_coeffs_ff <= csr_wdata;
            REG_PRESS_COEFFS_A: press_a_ff     <= csr_wdata;
            REG_PRESS_COEFFS_B: press_b_ff     <= csr_wdata;
            REG_PRESS_COEFFS_C: press_c_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = temp_coeffs_ff[15:0];
   assign t2 = $signed(temp_coeffs_ff[31:16]);
   assign t3 = $signed(temp_coeffs_ff[47:32]);
   assign p1 = press_a_ff[15:0];
   assign p2 = $signed(press_a_ff[31:16]);
   assign p3 = $signed(press_a_ff[47:32]);
   assign p4 = $signed(press_b_ff[15:0]);
   assign p5 = $signed(press_b_ff[31:16]);
   assign p6 = $signed(press_b_ff[47:32]);
   assign p7 = $signed(press_c_ff[15:0]);
   assign p8 = $signed(press_c_ff[31:16]);
   assign p9 = $signed(press_c_ff[47:32]);

   // ---------------- flow control ----------------
   logic [LATENCY-1:0] vld_ff;
   logic               adv;

   // advance every stage together unless a finished result is stalled
   assign adv        = !vld_ff[LATENCY-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_tvalid};
      end
   end

   // ---------------- front: temperature and pressure terms ----------------
   logic [19:0]        ut, up;
   assign ut = req_tdata[19:0];
   assign up = req_tdata[39:20];

   logic signed [31:0] a_ff, b_ff, m1_ff, bb_ff, tv1_ff, sq_ff, m2_ff, tv1d_ff, tf_ff;
   logic signed [32:0] v1_ff;
   logic signed [63:0] vv_ff, vvp6_ff, vvp3_ff, x_ff, y_ff, v2_ff, var1_ff;
   logic signed [48:0] v1p5_ff, v1p2_ff;
   logic signed [63:0] pm_ff, pn_ff, var1f_ff, num_ff;
   logic [19:0]        up_ff [1:9];
   side_type           sd_ff [0:5];

   logic signed [31:0] a_in, b_in, tmp5_in;
   logic signed [65:0] vv_full_in;
   logic signed [79:0] vvp6_full_in, vvp3_full_in;
   logic signed [63:0] v1p5_ext_in, v1p2_ext_in, p4_ext_in, pbase_in;
   logic signed [80:0] pm_full_in;
   side_type           sd0_in;

   always_comb begin
      a_in = $signed({15'd0, ut[19:3]}) - $signed({15'd0, t1, 1'b0});
      b_in = $signed({16'd0, ut[19:4]}) - $signed({16'd0, t1});
      tmp5_in = tf_ff * 32'sd5 + 32'sd128;
      sd0_in.temperature_centi = sdiv32(tmp5_in, 8);
      sd0_in.fine_temperature  = tf_ff;
      sd0_in.divisor_zero      = 1'b0;
      vv_full_in   = v1_ff * v1_ff;
      vvp6_full_in = vv_ff * p6;
      vvp3_full_in = vv_ff * p3;
      v1p5_ext_in  = v1p5_ff;
      v1p2_ext_in  = v1p2_ff;
      p4_ext_in    = p4;
      pm_full_in   = (var1_ff + VAR1_OFFSET) * $signed({1'b0, p1});
      pbase_in     = $signed((PRESS_FULL - {44'd0, up_ff[9]}) << 31);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         up_ff[1] <= up;
         m1_ff    <= a_ff * $signed({{16{t2[15]}}, t2});
         bb_ff    <= b_ff * b_ff;
         tv1_ff   <= sdiv32(m1_ff, 11);
         sq_ff    <= sdiv32(bb_ff, 12);
         m2_ff    <= sq_ff * $signed({{16{t3[15]}}, t3});
         tv1d_ff  <= tv1_ff;
         tf_ff    <= tv1d_ff + sdiv32(m2_ff, 14);
         v1_ff    <= $signed({tf_ff[31], tf_ff}) - TEMP_OFFSET;
         sd_ff[0] <= sd0_in;
         vv_ff    <= vv_full_in[63:0];
         v1p5_ff  <= v1_ff * p5;
         v1p2_ff  <= v1_ff * p2;
         vvp6_ff  <= vvp6_full_in[63:0];
         vvp3_ff  <= vvp3_full_in[63:0];
         x_ff     <= (v1p5_ext_in <<< 17) + (p4_ext_in <<< 35);
         y_ff     <= v1p2_ext_in <<< 12;
         v2_ff    <= vvp6_ff + x_ff;
         var1_ff  <= sdiv64(vvp3_ff, 8) + y_ff;
         pm_ff    <= pm_full_in[63:0];
         pn_ff    <= pbase_in - v2_ff;
         var1f_ff <= sdiv64(pm_ff, 33);
         num_ff   <= pn_ff * PRESS_SCALE;
      end
   end

   for (genvar i = 1; i < 9; i++) begin : g_up
      always_ff @(posedge clock) begin
         if (adv) begin
            up_ff[i+1] <= up_ff[i];
         end
      end
   end

   for (genvar i = 0; i < 5; i++) begin : g_sd
      always_ff @(posedge clock) begin
         if (adv) begin
            sd_ff[i+1] <= sd_ff[i];
         end
      end
   end

   // ---------------- divider: one quotient bit per stage ----------------
   logic [63:0] dv_rem_ff [0:DIV_STAGES];
   logic [63:0] dv_num_ff [0:DIV_STAGES];
   logic [63:0] dv_den_ff [0:DIV_STAGES];
   logic        dv_neg_ff [0:DIV_STAGES];
   side_type    dv_sd_ff  [0:DIV_STAGES];

   side_type    dsd_in;
   always_comb begin
      dsd_in              = sd_ff[5];
      dsd_in.divisor_zero = (var1f_ff == 64'sd0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0] <= '0;
         dv_num_ff[0] <= num_ff[63] ? 64'(-num_ff) : num_ff;
         dv_den_ff[0] <= var1f_ff[63] ? 64'(-var1f_ff) : var1f_ff;
         dv_neg_ff[0] <= num_ff[63] ^ var1f_ff[63];
         dv_sd_ff[0]  <= dsd_in;
      end
   end

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      logic [64:0] trial;
      logic [64:0] diff;
      logic        ge;
      assign trial = {dv_rem_ff[i], dv_num_ff[i][63]};
      assign diff  = trial - {1'b0, dv_den_ff[i]};
      assign ge    = trial >= {1'b0, dv_den_ff[i]};
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[i+1] <= ge ? diff[63:0] : trial[63:0];
            dv_num_ff[i+1] <= {dv_num_ff[i][62:0], ge};
            dv_den_ff[i+1] <= dv_den_ff[i];
            dv_neg_ff[i+1] <= dv_neg_ff[i];
            dv_sd_ff[i+1]  <= dv_sd_ff[i];
         end
      end
   end

   // ---------------- back: second-order pressure correction ----------------
   logic signed [63:0] quo;
   assign quo = dv_neg_ff[DIV_STAGES] ? $signed(-dv_num_ff[DIV_STAGES])
                                      : $signed(dv_num_ff[DIV_STAGES]);

   logic signed [63:0] bp1_ff, bp2_ff, bp3_ff, bp4_ff;
   logic signed [63:0] bqq1_ff, bqq2_ff, bw2m_ff, p9q_ff;
   logic signed [63:0] w2_2_ff, w2_3_ff, w2_4_ff, w1m_ff, s_ff;
   logic [63:0]        lolo_ff;
   logic [31:0]        lohi_ff, hilo_ff;
   side_type           bsd_ff [0:5];
   logic [31:0]        pres_ff;

   logic signed [79:0] bw2m_full_in, p9q_full_in;
   logic [31:0]        lohi_in, hilo_in;
   logic signed [63:0] p7_ext_in, pres_in;

   always_comb begin
      bw2m_full_in = quo * p8;
      p9q_full_in  = bqq1_ff * p9;
      lohi_in      = p9q_ff[31:0] * bqq2_ff[63:32];
      hilo_in      = p9q_ff[63:32] * bqq2_ff[31:0];
      p7_ext_in    = p7;
      pres_in      = sdiv64(s_ff, 8) + (p7_ext_in <<< 4);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bp1_ff    <= quo;
         bqq1_ff   <= sdiv64(quo, 13);
         bw2m_ff   <= bw2m_full_in[63:0];
         bsd_ff[0] <= dv_sd_ff[DIV_STAGES];
         bp2_ff    <= bp1_ff;
         bqq2_ff   <= bqq1_ff;
         p9q_ff    <= p9q_full_in[63:0];
         w2_2_ff   <= sdiv64(bw2m_ff, 19);
         bp3_ff    <= bp2_ff;
         w2_3_ff   <= w2_2_ff;
         lolo_ff   <= p9q_ff[31:0] * bqq2_ff[31:0];
         lohi_ff   <= lohi_in;
         hilo_ff   <= hilo_in;
         bp4_ff    <= bp3_ff;
         w2_4_ff   <= w2_3_ff;
         w1m_ff    <= $signed(lolo_ff + {lohi_ff + hilo_ff, 32'd0});
         s_ff      <= bp4_ff + sdiv64(w1m_ff, 25) + w2_4_ff;
         // drop the pressure when the divisor was zero
         pres_ff   <= bsd_ff[4].divisor_zero ? 32'd0 : pres_in[31:0];
      end
   end

   for (genvar i = 0; i < 5; i++) begin : g_bsd
      always_ff @(posedge clock) begin
         if (adv) begin
            bsd_ff[i+1] <= bsd_ff[i];
         end
      end
   end

   assign rsp_tdata = {pres_ff, bsd_ff[5].fine_temperature, bsd_ff[5].temperature_centi};
   assign rsp_tuser = bsd_ff[5].divisor_zero;

   // ---------------- assertions ----------------
   a_zero_press: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[95:64] == 32'd0)
      else $error("pressure not zero on zero divisor");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted transaction not captured");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> vld_ff == '0)
      else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// File: sim/tb_barometric_pressure_compensation_unit.sv
// Self-checking testbench for the barometric pressure compensation unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_barometric_pressure_compensation_unit;
   import bpc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } reading_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic signed [31:0] fine_temperature;
      logic [31:0]        pressure_q24_8;
      logic               divisor_zero;
   } compensated_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Calibration shadow copy, updated when the stimulus writes a register.
   logic [47:0] calib [4];

   reading_type     pending_readings [$];
   compensated_type expected_results [$];
   reading_type     presented;
   int              send_gap = 0;
   int              recv_stall = 0;
   int              max_gap = 12;
   int              max_stall = 12;
   int              failures = 0;
   int              checked = 0;
   int              dz_seen = 0;
   int              cycles = 0;

   barometric_pressure_compensation_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Integer compensation: 32-bit wrapping temperature path, 64-bit wrapping
   // pressure path, every division truncating toward zero.
   function automatic compensated_type compensate(reading_type rd);
      compensated_type res;
      int     ut, t1, t2, t3, a, tv1, b, sq, tv2, tf;
      longint up, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint v1, v2, p, q, w1, w2, num;
      ut = int'(rd.raw_temperature);
      up = longint'(rd.raw_pressure);
      t1 = int'(calib[0][15:0]);
      t2 = int'($signed(calib[0][31:16]));
      t3 = int'($signed(calib[0][47:32]));
      p1 = longint'(calib[1][15:0]);
      p2 = longint'($signed(calib[1][31:16]));
      p3 = longint'($signed(calib[1][47:32]));
      p4 = longint'($signed(calib[2][15:0]));
      p5 = longint'($signed(calib[2][31:16]));
      p6 = longint'($signed(calib[2][47:32]));
      p7 = longint'($signed(calib[3][15:0]));
      p8 = longint'($signed(calib[3][31:16]));
      p9 = longint'($signed(calib[3][47:32]));

      a   = ut / 8 - 2 * t1;
      tv1 = (a * t2) / 2048;
      b   = ut / 16 - t1;
      sq  = (b * b) / 4096;
      tv2 = (sq * t3) / 16384;
      tf  = tv1 + tv2;
      res.fine_temperature  = tf;
      res.temperature_centi = (tf * 5 + 128) / 256;

      v1 = longint'(tf) - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + v1 * p5 * 64'sd131072;
      v2 = v2 + p4 * 64'sd34359738368;
      v1 = (v1 * v1 * p3) / 64'sd256 + v1 * p2 * 64'sd4096;
      v1 = ((64'sh0000_8000_0000_0000 + v1) * p1) / 64'sd8589934592;

      res.pressure_q24_8 = '0;
      res.divisor_zero   = (v1 == 0);
      if (v1 != 0) begin
         p   = 64'sd1048576 - up;
         num = (p * 64'sd2147483648 - v2) * 64'sd3125;
         // a divisor of minus one negates, wrapping the most negative value
         p   = (v1 == -64'sd1) ? -num : num / v1;
         q   = p / 64'sd8192;
         w1  = (p9 * q * q) / 64'sd33554432;
         w2  = (p8 * p) / 64'sd524288;
         p   = (p + w1 + w2) / 64'sd256 + p7 * 64'sd16;
         res.pressure_q24_8 = p[31:0];
      end
      return res;
   endfunction

   // Driver: present queued readings, with a random gap after each transaction.
   always @(posedge clock) begin
      int          gap;
      reading_type nxt;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, expected_results.size());
         $display("barometric_pressure_compensation_unit verification failed");
         $finish;
      end
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(compensate(presented));
            gap = $urandom_range(0, max_gap);
            if (gap == 0 && pending_readings.size() > 0) begin
               nxt = pending_readings.pop_front();
               presented <= nxt;
               req_tdata <= {nxt.raw_pressure, nxt.raw_temperature};
            end else begin
               send_gap   <= gap;
               req_tvalid <= 1'b0;
            end
         end else if (!req_tvalid) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (pending_readings.size() > 0) begin
               nxt = pending_readings.pop_front();
               presented  <= nxt;
               req_tdata  <= {nxt.raw_pressure, nxt.raw_temperature};
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // Monitor: check each result against the oldest expectation, stall at random.
   always @(posedge clock) begin
      compensated_type exp_res;
      int              stall;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            checked <= checked + 1;
            if (expected_results.size() == 0) begin
               $display("%0t unexpected result: actual %h/%b", $time, rsp_tdata, rsp_tuser);
               failures = failures + 1;
            end else begin
               exp_res = expected_results.pop_front();
               if (exp_res.divisor_zero) dz_seen <= dz_seen + 1;
               if (rsp_tdata[31:0] !== exp_res.temperature_centi) begin
                  $display("%0t temperature_centi mismatch: expected %0d actual %0d", $time,
                           exp_res.temperature_centi, $signed(rsp_tdata[31:0]));
                  failures = failures + 1;
               end
               if (rsp_tdata[63:32] !== exp_res.fine_temperature) begin
                  $display("%0t fine_temperature mismatch: expected %0d actual %0d", $time,
                           exp_res.fine_temperature, $signed(rsp_tdata[63:32]));
                  failures = failures + 1;
               end
               if (rsp_tdata[95:64] !== exp_res.pressure_q24_8) begin
                  $display("%0t pressure_q24_8 mismatch: expected %h actual %h", $time,
                           exp_res.pressure_q24_8, rsp_tdata[95:64]);
                  failures = failures + 1;
               end
               if (rsp_tuser !== exp_res.divisor_zero) begin
                  $display("%0t divisor_zero mismatch: expected %b actual %b", $time,
                           exp_res.divisor_zero, rsp_tuser);
                  failures = failures + 1;
               end
            end
            stall = $urandom_range(0, max_stall);
            recv_stall <= stall;
            rsp_tready <= (stall == 0);
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_tready <= (recv_stall == 1);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [47:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      calib[idx] = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_calibration(logic [47:0] tc, logic [47:0] pa,
                                   logic [47:0] pb, logic [47:0] pc);
      write_csr(REG_TEMP_COEFFS, tc);
      write_csr(REG_PRESS_COEFFS_A, pa);
      write_csr(REG_PRESS_COEFFS_B, pb);
      write_csr(REG_PRESS_COEFFS_C, pc);
   endtask

   task automatic queue_reading(logic [19:0] rt, logic [19:0] rp);
      reading_type rd;
      rd.raw_temperature = rt;
      rd.raw_pressure    = rp;
      pending_readings.push_back(rd);
   endtask

   // Random readings: half with one field at zero or all ones, half fully random.
   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: queue_reading(20'($urandom_range(0, 20'hFFFFF)),
                             $urandom_range(0, 1) ? 20'hFFFFF : 20'h0);
            1: queue_reading($urandom_range(0, 1) ? 20'hFFFFF : 20'h0,
                             20'($urandom_range(0, 20'hFFFFF)));
            default: queue_reading(20'($urandom_range(0, 20'hFFFFF)),
                                   20'($urandom_range(0, 20'hFFFFF)));
         endcase
      end
   endtask

   // Hold until the sender and receiver are both idle, then let the pipe drain.
   task automatic drain;
      while (pending_readings.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   function automatic logic [47:0] random_reg;
      return {16'($urandom), 16'($urandom), 16'($urandom)};
   endfunction

   initial begin
      for (int i = 0; i < 4; i++) calib[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset calibration: P1 is zero, so every divisor is zero.
      queue_reading(20'h0, 20'h0);
      queue_reading(20'hFFFFF, 20'hFFFFF);
      queue_reading(20'h80000, 20'h12345);
      drain();

      // Typical factory coefficients with field extremes and single-bit walks.
      load_calibration({16'hFC18, 16'd26435, 16'd27504},
                       {16'd3024, 16'hD643, 16'd36477},
                       {16'hFFF9, 16'd140, 16'd2855},
                       {16'd6000, 16'hC6F8, 16'd15500});
      queue_reading(20'h0, 20'h0);
      queue_reading(20'hFFFFF, 20'hFFFFF);
      queue_reading(20'h0, 20'hFFFFF);
      queue_reading(20'hFFFFF, 20'h0);
      queue_reading(20'd519888, 20'd415148);
      for (int i = 0; i < 20; i += 2) queue_reading(20'h1 << i, 20'h1 << (19 - i));
      queue_random(60);
      drain();

      // Extremes: all ones, then most positive and most negative slices.
      max_gap = 0;
      max_stall = 0;
      load_calibration('1, '1, '1, '1);
      queue_random(40);
      drain();
      max_gap = 12;
      max_stall = 12;
      load_calibration({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'hFFFF},
                       {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF});
      queue_random(40);
      drain();
      load_calibration({16'h8000, 16'h8000, 16'h0001}, {16'h8000, 16'h8000, 16'h0001},
                       {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000});
      queue_random(40);
      drain();

      // Random calibration sets, alternating idle-free and idling stretches.
      for (int ph = 0; ph < 5; ph++) begin
         max_gap   = (ph % 2) ? 0 : 12;
         max_stall = (ph % 3) ? 12 : 0;
         load_calibration(random_reg(), random_reg(), random_reg(), random_reg());
         queue_random(45);
         drain();
      end

      $display("Checked %0d results over 10 calibration sets, %0d with a zero divisor.",
               checked, dz_seen);
      if (failures == 0) begin
         $display("barometric_pressure_compensation_unit verification clean");
      end else begin
         $display("barometric_pressure_compensation_unit verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: files.f
design/bpc_pkg.sv
design/barometric_pressure_compensation_unit.sv
sim/tb_barometric_pressure_compensation_unit.sv
